@@ rtl/sparse_grid_point_count_unit_assert.svh @@
`ifndef SPARSE_GRID_POINT_COUNT_UNIT_ASSERT_SVH
`define SPARSE_GRID_POINT_COUNT_UNIT_ASSERT_SVH

// Check that a condition implies a property in the same cycle.
`define SGPC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("sparse grid point count unit: check failed");

// Check that a condition implies a property in the following cycle.
`define SGPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error("sparse grid point count unit: check failed");

`endif

@@ rtl/sgpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sgpc_pkg;

   localparam int DIM_W       = 4;
   localparam int LEVEL_W     = 4;
   localparam int COUNT_W     = 48;
   localparam int ACC_W       = 32;
   localparam int DVS_W       = 5;
   localparam int DIV_CNT_W   = $clog2(ACC_W);
   localparam int MAX_DIM_DEF   = 15;
   localparam int MAX_LEVEL_DEF = 15;
   localparam int STEP_W      = 3;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_INIT  = 3'd0;
   localparam step_type STEP_TEST  = 3'd1;
   localparam step_type STEP_ADD   = 3'd2;
   localparam step_type STEP_MUL   = 3'd3;
   localparam step_type STEP_DIVGO = 3'd4;
   localparam step_type STEP_QUOT  = 3'd5;
   localparam step_type STEP_ONE   = 3'd6;
   localparam step_type STEP_DONE  = 3'd7;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_INIT,
      OP_ADD,
      OP_MUL,
      OP_DIVGO,
      OP_QUOT,
      OP_ONE,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DIM_ZERO,
      COND_LEVEL_END,
      COND_DIV_WAIT
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctl_type;

   typedef struct packed {
      logic dim_zero;
      logic level_end;
      logic div_done;
   } status_type;

   // Microcode: running binomial C(d-1+j, j), updated by *(d+j)/(j+1) per level.
   function automatic ctl_type ucode(step_type s);
      ctl_type w;
      unique case (s)
         STEP_INIT:  w = '{op: OP_INIT,  cond: COND_DIM_ZERO,  target: STEP_ONE};
         STEP_TEST:  w = '{op: OP_NOP,   cond: COND_LEVEL_END, target: STEP_DONE};
         STEP_ADD:   w = '{op: OP_ADD,   cond: COND_NEXT,      target: STEP_INIT};
         STEP_MUL:   w = '{op: OP_MUL,   cond: COND_NEXT,      target: STEP_INIT};
         STEP_DIVGO: w = '{op: OP_DIVGO, cond: COND_NEXT,      target: STEP_INIT};
         STEP_QUOT:  w = '{op: OP_QUOT,  cond: COND_DIV_WAIT,  target: STEP_TEST};
         STEP_ONE:   w = '{op: OP_ONE,   cond: COND_NEXT,      target: STEP_INIT};
         STEP_DONE:  w = '{op: OP_DONE,  cond: COND_ALWAYS,    target: STEP_INIT};
         default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,    target: STEP_INIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sgpc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgpc_div
   import sgpc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ACC_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic      [ACC_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [ACC_W-1:0]     quo_ff, quo_in;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[ACC_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(ACC_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // one restoring step per cycle, quotient bits shift in at the bottom
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[ACC_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/sgpc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgpc_datapath
   import sgpc_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire logic [DIM_W-1:0]   dimensions,
   input  wire logic [LEVEL_W-1:0] refinement_level,
   input  wire ctl_type            ctl,
   output status_type              status,
   output logic      [COUNT_W-1:0] point_count
);

   logic [DIM_W-1:0]   dims_ff, dims_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [LEVEL_W-1:0] j_ff, j_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   prod_ff, prod_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [DVS_W-1:0]   factor;
   logic [DVS_W-1:0]   divisor;
   logic [ACC_W+DVS_W-1:0] product;
   logic               div_start;
   logic               div_done;
   logic [ACC_W-1:0]   quotient;

   assign factor    = {1'b0, dims_ff} + {1'b0, j_ff};
   assign divisor   = {1'b0, j_ff} + 1'b1;
   assign product   = acc_ff * factor;
   assign div_start = ctl.op == OP_DIVGO;

   sgpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      dims_in  = dims_ff;
      lvl_in   = lvl_ff;
      j_in     = j_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      total_in = total_ff;
      if (load) begin
         // clamp to the configured limits
         dims_in = (dimensions > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dimensions;
         lvl_in  = (refinement_level > LEVEL_W'(MAX_LEVEL)) ?
                   LEVEL_W'(MAX_LEVEL) : refinement_level;
      end
      unique case (ctl.op)
         OP_INIT: begin
            acc_in   = ACC_W'(1);
            total_in = '0;
            j_in     = '0;
         end
         OP_ADD:   total_in = total_ff + (COUNT_W'(acc_ff) << j_ff);
         OP_MUL:   prod_in  = product[ACC_W-1:0];
         OP_QUOT: begin
            if (div_done) begin
               acc_in = quotient;
               j_in   = j_ff + 1'b1;
            end
         end
         OP_ONE:   total_in = COUNT_W'(1);
         OP_NOP, OP_DIVGO, OP_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
      end else begin
         j_ff <= j_in;
      end
      dims_ff  <= dims_in;
      lvl_ff   <= lvl_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      total_ff <= total_in;
   end

   assign status.dim_zero  = dims_ff == '0;
   assign status.level_end = j_ff == lvl_ff;
   assign status.div_done  = div_done;
   assign point_count      = total_ff;

endmodule

`default_nettype wire

@@ rtl/sgpc_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgpc_sequencer
   import sgpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output logic            busy,
   output logic            load,
   output ctl_type         ctl,
   output logic            done
);

   logic     busy_ff, busy_in;
   step_type step_ff, step_in;
   ctl_type  word;
   step_type step_inc;

   assign word     = ucode(step_ff);
   assign step_inc = step_ff + 1'b1;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      load    = 1'b0;
      ctl     = '{op: OP_NOP, cond: COND_NEXT, target: STEP_INIT};
      done    = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            load    = 1'b1;
            busy_in = 1'b1;
            step_in = STEP_INIT;
         end
      end else begin
         ctl = word;
         if (word.op == OP_DONE) begin
            done    = 1'b1;
            busy_in = 1'b0;
         end
         unique case (word.cond)
            COND_NEXT:      step_in = step_inc;
            COND_ALWAYS:    step_in = word.target;
            COND_DIM_ZERO:  step_in = status.dim_zero ? word.target : step_inc;
            COND_LEVEL_END: step_in = status.level_end ? word.target : step_inc;
            // hold until the divider finishes
            COND_DIV_WAIT:  step_in = status.div_done ? word.target : step_ff;
            default:        step_in = STEP_INIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_INIT;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

@@ rtl/sparse_grid_point_count_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sparse grid point count, zero boundary.
// Raise start with req_dimensions and req_refinement_level; the transaction
// is taken at the clock edge where start is high and busy is low. busy then
// stays high until the result is delivered.
// The result appears on rsp_point_count for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall it and must take it in that cycle.
// The count is the sum over levels j below n of 2^j * C(d-1+j, j), built by
// a microcoded sequencer that steps a small datapath: per level it adds the
// running binomial, multiplies by d+j and divides by j+1 in a bit-serial
// divider.
// One transaction at a time; a new one may start the cycle after the result.
// Reset is synchronous and active high; it returns the sequencer to idle and
// drops any transaction in flight.

module sparse_grid_point_count_unit
   import sgpc_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [DIM_W-1:0]   req_dimensions,
   input  wire logic [LEVEL_W-1:0] req_refinement_level,
   output logic                    rsp_valid,
   output logic      [COUNT_W-1:0] rsp_point_count
);

`include "sparse_grid_point_count_unit_assert.svh"

   ctl_type    ctl;
   status_type status;
   logic       load;
   logic       zero_dim_take;

   sgpc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .load   (load),
      .ctl    (ctl),
      .done   (rsp_valid)
   );

   sgpc_datapath #(
      .MAX_DIM   (MAX_DIM),
      .MAX_LEVEL (MAX_LEVEL)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .dimensions       (req_dimensions),
      .refinement_level (req_refinement_level),
      .ctl              (ctl),
      .status           (status),
      .point_count      (rsp_point_count)
   );

   assign zero_dim_take = start && !busy && req_dimensions == '0;

   `SGPC_ASSERT_SAME(a_rsp_in_run, rsp_valid, busy)
   `SGPC_ASSERT_NEXT(a_rsp_ends_run, rsp_valid, !busy)
   `SGPC_ASSERT_SAME(a_zero_dim, zero_dim_take, ##3 (rsp_valid && rsp_point_count == COUNT_W'(1)))

endmodule

`default_nettype wire
